>>> rtl/tse_pkg.sv
// Package for the topological sort engine: sizes, state type, controller/datapath bundles.
// No dependencies.
package tse_pkg;

   localparam int MaxVertices = 64;
   localparam int MaxEdges    = 256;
   localparam int VW          = 6;   // vertex index width
   localparam int EW          = 8;   // edge index width
   localparam int CW          = 9;   // edge pointer width, MSB set means nil
   localparam int FW          = 7;   // fill / stack depth width

   localparam logic [1:0] StatusOrdered  = 2'd0;
   localparam logic [1:0] StatusCycle    = 2'd1;
   localparam logic [1:0] StatusOverflow = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_ROOT,
      ST_TOP_RD,
      ST_EDGE_RD,
      ST_STEP,
      ST_EMIT,
      ST_REPORT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic add_rd;     // capture edge, read tail of source
      logic add_wr;     // write edge record and list links
      logic root_chk;   // examine root candidate, push if unvisited
      logic root_next;
      logic top_rd;     // read top-of-stack entry
      logic edge_rd;    // read edge record at cursor
      logic step;       // apply one walk decision
      logic emit_pop;   // output transfer taken
      logic clear;      // reset graph and marks
   } cmd_type;

   typedef struct packed {
      logic add_bad;
      logic root_done;
      logic root_visited;
      logic cursor_nil;
      logic stack_last; // one entry left on the walk stack
      logic cycle;      // back edge at the current step
      logic overflow;
      logic emit_empty;
      logic emit_final;
   } stat_type;

endpackage

>>> rtl/tse_ctrl.sv
// Controller state machine of the topological sort engine.
// Depends on tse_pkg.
module tse_ctrl
   import tse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     req_func,
   output logic     req_tready,
   input  logic     rsp_tready,
   output logic     rsp_tvalid,
   output logic     rsp_report,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type state_ff, state_in;
   logic      go;

   assign go = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               if (!req_func) state_in = ST_ADD_RD;
               else if (stat.overflow) state_in = ST_REPORT;
               else state_in = ST_ROOT;
            end
         end
         ST_ADD_RD: state_in = stat.add_bad ? ST_IDLE : ST_ADD_WR;
         ST_ADD_WR: state_in = ST_IDLE;
         ST_ROOT: begin
            if (stat.root_done) state_in = ST_EMIT;
            else if (!stat.root_visited) state_in = ST_TOP_RD;
         end
         ST_TOP_RD: state_in = ST_EDGE_RD;
         ST_EDGE_RD: state_in = ST_STEP;
         ST_STEP: begin
            if (stat.cycle) state_in = ST_REPORT;
            else if (stat.cursor_nil && stat.stack_last) state_in = ST_ROOT;
            else state_in = ST_TOP_RD;
         end
         ST_EMIT: begin
            if (stat.emit_empty) state_in = ST_CLEAR;
            else if (rsp_tready && stat.emit_final) state_in = ST_CLEAR;
         end
         ST_REPORT: if (rsp_tready) state_in = ST_CLEAR;
         ST_CLEAR: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // the datapath advances the root itself when a pop empties the stack
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_report = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.add_rd    = go && !req_func;
         end
         ST_ADD_RD:  cmd.add_wr = !stat.add_bad;
         ST_ROOT: begin
            cmd.root_chk  = !stat.root_done;
            cmd.root_next = !stat.root_done && stat.root_visited;
         end
         ST_TOP_RD:  cmd.top_rd = 1'b1;
         ST_EDGE_RD: cmd.edge_rd = 1'b1;
         ST_STEP:    cmd.step = 1'b1;
         ST_EMIT: begin
            rsp_tvalid   = !stat.emit_empty;
            cmd.emit_pop = rsp_tready && !stat.emit_empty;
         end
         ST_REPORT: begin
            rsp_tvalid = 1'b1;
            rsp_report = 1'b1;
         end
         ST_CLEAR:   cmd.clear = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT && rsp_tready) |=> (state_ff == ST_CLEAR))
      else $error("report not followed by clear");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> req_tready)
      else $error("not ready after clear");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("accepting input while emitting");

endmodule

>>> rtl/tse_dp.sv
// Datapath of the topological sort engine: edge store, adjacency lists, marks,
// walk stack and order buffer. Depends on tse_pkg.
module tse_dp
   import tse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [6:0]    csr_wdata,
   input  logic [VW-1:0] req_source,
   input  logic [VW-1:0] req_target,
   input  logic          rsp_report,
   output logic [VW-1:0] rsp_vertex,
   output logic [1:0]    rsp_status,
   output logic          rsp_last,
   input  cmd_type       cmd,
   output stat_type      stat
);

   // memories (entries read only after being written)
   logic [VW-1:0] edge_target_mem [MaxEdges];
   logic [CW-1:0] edge_next_mem   [MaxEdges];
   logic [EW-1:0] tail_mem        [MaxVertices];
   logic [VW-1:0] stk_vertex_mem  [MaxVertices];
   logic [CW-1:0] stk_cursor_mem  [MaxVertices];
   logic [VW-1:0] order_mem       [MaxVertices];

   logic [6:0]          vcount_ff;
   logic [FW-1:0]       nvert;
   logic [MaxVertices-1:0] head_valid_ff, visited_ff, on_path_ff;
   logic [CW-1:0]       head_ff [MaxVertices];
   logic [CW-1:0]       head_rd_ff;
   logic                fresh_ff;
   logic [CW-1:0]       edge_count_ff;
   logic                overflow_ff;
   logic                add_chk_ff;
   logic [VW-1:0]       src_ff, dst_ff;
   logic [EW-1:0]       tail_rd_ff;
   logic [FW-1:0]       root_ff, sp_ff, fill_ff;
   logic [VW-1:0]       top_v_ff;
   logic [CW-1:0]       top_c_ff;
   logic [VW-1:0]       w_ff;
   logic [CW-1:0]       nxt_ff;
   logic [VW-1:0]       order_rd_ff;
   logic [FW-1:0]       rd_idx;
   logic [VW-1:0]       root_v;
   logic [VW-1:0]       head_addr;
   logic [FW-1:0]       top_idx;
   logic                w_in_range, push, pop;
   logic [CW-1:0]       nil;

   assign nil = CW'(MaxEdges);
   always_comb begin
      if (vcount_ff == 7'd0) nvert = 7'd1;
      else if (vcount_ff > 7'(MaxVertices)) nvert = 7'(MaxVertices);
      else nvert = vcount_ff;
   end

   assign stat.add_bad = ({1'b0, src_ff} >= nvert) || ({1'b0, dst_ff} >= nvert) ||
                         (edge_count_ff >= CW'(MaxEdges));
   assign root_v            = root_ff[VW-1:0];
   assign stat.root_done    = root_ff >= nvert;
   assign stat.root_visited = visited_ff[root_v];
   assign stat.cursor_nil   = top_c_ff[CW-1];
   assign stat.stack_last   = sp_ff == 7'd1;
   assign stat.cycle        = !top_c_ff[CW-1] && w_in_range && visited_ff[w_ff]
                              && on_path_ff[w_ff];
   assign stat.overflow     = overflow_ff;
   assign stat.emit_empty   = fill_ff == '0;
   assign stat.emit_final   = fill_ff == 7'd1;
   assign top_idx           = sp_ff - 7'd1;
   assign w_in_range        = {1'b0, w_ff} < nvert;
   assign push = cmd.step && !stat.cursor_nil && w_in_range && !visited_ff[w_ff]
                 && (sp_ff < 7'(MaxVertices));
   assign pop  = cmd.step && stat.cursor_nil;
   assign rd_idx = cmd.emit_pop ? fill_ff - 7'd2 : fill_ff - 7'd1;
   // head of the vertex being pushed: the root in ST_ROOT, the edge target in ST_STEP
   assign head_addr = cmd.step ? w_ff : root_v;

   // stack memory and top read; a freshly pushed entry takes its cursor from the head read
   always_ff @(posedge clock) begin
      if (cmd.root_chk && !stat.root_visited) stk_vertex_mem[0] <= root_v;
      else if (push) stk_vertex_mem[sp_ff[VW-1:0]] <= w_ff;
      if (cmd.step && !stat.cursor_nil) stk_cursor_mem[top_idx[VW-1:0]] <= nxt_ff;
      head_rd_ff <= head_valid_ff[head_addr] ? head_ff[head_addr] : nil;
      if (cmd.top_rd) begin
         top_v_ff <= stk_vertex_mem[top_idx[VW-1:0]];
         top_c_ff <= fresh_ff ? head_rd_ff : stk_cursor_mem[top_idx[VW-1:0]];
      end
   end

   // edge store reads/writes
   always_ff @(posedge clock) begin
      if (cmd.add_rd) tail_rd_ff <= tail_mem[req_source];
      if (cmd.add_wr) begin
         edge_target_mem[edge_count_ff[EW-1:0]] <= dst_ff;
         edge_next_mem[edge_count_ff[EW-1:0]]   <= nil;
         tail_mem[src_ff] <= edge_count_ff[EW-1:0];
      end else if (cmd.edge_rd && !top_c_ff[CW-1]) begin
         w_ff   <= edge_target_mem[top_c_ff[EW-1:0]];
         nxt_ff <= edge_next_mem[top_c_ff[EW-1:0]];
      end
      if (cmd.add_wr && head_valid_ff[src_ff])
         edge_next_mem[tail_rd_ff] <= edge_count_ff;
   end

   // order buffer
   always_ff @(posedge clock) begin
      if (pop) order_mem[fill_ff[VW-1:0]] <= top_v_ff;
      order_rd_ff <= order_mem[rd_idx[VW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.add_rd) begin
         src_ff <= req_source;
         dst_ff <= req_target;
      end
      if (cmd.add_wr && !head_valid_ff[src_ff]) head_ff[src_ff] <= edge_count_ff;
   end

   // high in the cycle after an edge transfer, when the range check is made
   always_ff @(posedge clock) begin
      if (reset) add_chk_ff <= 1'b0;
      else add_chk_ff <= cmd.add_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 7'(MaxVertices);
      end else if (csr_we) begin
         vcount_ff <= csr_wdata;
      end
      if (reset || cmd.clear) begin
         head_valid_ff     <= '0;
         visited_ff        <= '0;
         on_path_ff        <= '0;
         edge_count_ff     <= '0;
         overflow_ff       <= 1'b0;
         fresh_ff          <= 1'b0;
         root_ff           <= '0;
         sp_ff             <= '0;
         fill_ff           <= '0;
      end else begin
         if (cmd.add_wr) begin
            head_valid_ff[src_ff] <= 1'b1;
            edge_count_ff <= edge_count_ff + CW'(1);
         end
         if (add_chk_ff && stat.add_bad) overflow_ff <= 1'b1;
         if (cmd.root_next) root_ff <= root_ff + 7'd1;
         if (cmd.root_chk && !stat.root_visited) begin
            visited_ff[root_v] <= 1'b1;
            on_path_ff[root_v] <= 1'b1;
            sp_ff <= 7'd1;
            fresh_ff <= 1'b1;
         end
         if (push) begin
            visited_ff[w_ff] <= 1'b1;
            on_path_ff[w_ff] <= 1'b1;
            sp_ff <= sp_ff + 7'd1;
            fresh_ff <= 1'b1;
         end
         if (cmd.top_rd) fresh_ff <= 1'b0;
         if (pop) begin
            on_path_ff[top_v_ff] <= 1'b0;
            fill_ff <= fill_ff + 7'd1;
            sp_ff <= sp_ff - 7'd1;
            if (sp_ff == 7'd1) root_ff <= root_ff + 7'd1;
         end
         if (cmd.emit_pop) fill_ff <= fill_ff - 7'd1;
      end
   end

   assign rsp_vertex = rsp_report ? '0 : order_rd_ff;
   assign rsp_status = rsp_report ? (overflow_ff ? StatusOverflow : StatusCycle)
                                  : StatusOrdered;
   assign rsp_last   = rsp_report ? 1'b1 : (fill_ff == 7'd1);

   assert property (@(posedge clock) disable iff (reset)
      push |=> visited_ff[$past(w_ff)])
      else $error("pushed vertex not marked");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> sp_ff != '0)
      else $error("pop on empty stack");
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= 7'(MaxVertices)))
      else $error("order buffer overfilled");

endmodule

>>> rtl/topological_sort_engine.sv
// Top level of the topological sort engine: ties the controller to the datapath.
// Depends on tse_pkg, tse_ctrl, tse_dp.
//
// Usage:
//  req_*: edge items (func 0) are taken one at a time, each through a read
//  and a write state (no write when dropped as out of range or past the store).
//  A finish item (func 1) starts a depth-first walk over vertices 0 to
//  vertex_count-1 (count clamped to 1..64); each edge visited and each vertex
//  popped passes the top read, edge read and step states, each root the root state.
//  rsp_*: then the vertices stream out in reverse postorder, one transfer per
//  cycle while rsp_tready is high, tlast on the final one; or one transfer with
//  status cycle/overflow. No new item is accepted until the last result is
//  taken and the clearing state has run; a stalled rsp_tready holds the current result.
//  csr_*: writes vertex_count (7 bits); write only while idle.
//  reset (synchronous) empties the graph and sets vertex_count to 64.
module topological_sort_engine
   import tse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,   // vertex_count
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] func, [6:1] source, [12:7] target, zero fill
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [7:0]  rsp_tdata,   // [5:0] vertex, [7:6] status
   output logic        rsp_tlast
);

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_report;

   tse_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_func(req_tdata[0]), .req_tready,
      .rsp_tready, .rsp_tvalid, .rsp_report, .cmd, .stat
   );

   tse_dp u_dp (
      .clock, .reset, .csr_we, .csr_wdata,
      .req_source(req_tdata[6:1]),
      .req_target(req_tdata[12:7]), .rsp_report,
      .rsp_vertex(rsp_tdata[5:0]), .rsp_status(rsp_tdata[7:6]),
      .rsp_last(rsp_tlast), .cmd, .stat
   );

endmodule

>>> verif/tb_topological_sort_engine.sv
// Testbench for topological_sort_engine: loads random and directed graphs, runs the
// sort and checks every output transfer against a depth-first order predictor.
// Depends on tse_pkg and the topological_sort_engine RTL.
module tb_topological_sort_engine
   import tse_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic FuncAdd    = 1'b0;
   localparam logic FuncFinish = 1'b1;
   localparam int   WatchLimit = 200000;

   typedef struct packed {
      logic [5:0] vertex;
      logic [1:0] status;
      logic       last;
   } order_item_type;

   typedef struct {
      logic       func;
      logic [5:0] src;
      logic [5:0] dst;
      logic       typed;     // expected result typed in below
      logic [1:0] status;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tready = 1'b0;
   logic        rsp_tvalid;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   topological_sort_engine dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [6:0]  vcount_reg;
   logic [8:0]  adj_head [64];
   logic [8:0]  adj_tail [64];
   logic [5:0]  e_target [256];
   logic [8:0]  e_next   [256];
   int          e_count;
   logic        bad_edge;
   order_item_type pending_order [$];

   int  errors = 0;
   int  idle_count = 0;
   bit  quiet = 1'b0;
   int  rsp_stall = 0;

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   function automatic int eff_count();
      int n;
      n = vcount_reg;
      if (n == 0) n = 1;
      if (n > 64) n = 64;
      return n;
   endfunction

   function automatic void clear_graph();
      for (int i = 0; i < 64; i++) adj_head[i] = 9'd256;
      e_count = 0;
      bad_edge = 1'b0;
   endfunction

   function automatic void load_edge(input logic [5:0] s, input logic [5:0] d);
      int n;
      n = eff_count();
      if (s >= n || d >= n || e_count >= 256) begin
         bad_edge = 1'b1;
         return;
      end
      e_target[e_count] = d;
      e_next[e_count] = 9'd256;
      if (adj_head[s] >= 256) adj_head[s] = e_count[8:0];
      else e_next[adj_tail[s]] = e_count[8:0];
      adj_tail[s] = e_count[8:0];
      e_count++;
   endfunction

   // Depth-first walk; queues reverse postorder or one error result.
   function automatic void sort_graph();
      int n, sp, fill, v, w;
      logic [8:0] c;
      bit seen [64], path [64], loop_found;
      int stk_v [64];
      logic [8:0] stk_c [64];
      int post [64];
      order_item_type r;
      n = eff_count();
      fill = 0;
      loop_found = 0;
      for (int i = 0; i < 64; i++) begin
         seen[i] = 0;
         path[i] = 0;
      end
      if (bad_edge) begin
         r.vertex = '0; r.status = StatusOverflow; r.last = 1'b1;
         pending_order.push_back(r);
         clear_graph();
         return;
      end
      for (int root = 0; root < n && !loop_found; root++) begin
         if (seen[root]) continue;
         seen[root] = 1; path[root] = 1;
         stk_v[0] = root; stk_c[0] = adj_head[root]; sp = 1;
         while (sp > 0 && !loop_found) begin
            v = stk_v[sp-1];
            c = stk_c[sp-1];
            if (c < 256) begin
               w = e_target[c];
               stk_c[sp-1] = e_next[c];
               if (w >= n) continue;
               if (!seen[w]) begin
                  if (sp >= 64) continue;
                  seen[w] = 1; path[w] = 1;
                  stk_v[sp] = w; stk_c[sp] = adj_head[w]; sp++;
               end else if (path[w]) loop_found = 1;
            end else begin
               path[v] = 0;
               if (fill < 64) post[fill++] = v;
               sp--;
            end
         end
      end
      if (loop_found) begin
         r.vertex = '0; r.status = StatusCycle; r.last = 1'b1;
         pending_order.push_back(r);
      end else begin
         for (int k = 0; k < fill; k++) begin
            r.vertex = 6'(post[fill-1-k]); r.status = StatusOrdered;
            r.last = (k + 1 == fill);
            pending_order.push_back(r);
         end
      end
      clear_graph();
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      order_item_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_order.size() == 0)
            report_mismatch($sformatf("unexpected result %h last %b", rsp_tdata, rsp_tlast));
         else begin
            exp_r = pending_order[0];
            pending_order.delete(0);
            if (rsp_tdata[5:0] !== exp_r.vertex)
               report_mismatch($sformatf("vertex %0d exp %0d", rsp_tdata[5:0], exp_r.vertex));
            if (rsp_tdata[7:6] !== exp_r.status)
               report_mismatch($sformatf("status %0d exp %0d", rsp_tdata[7:6], exp_r.status));
            if (rsp_tlast !== exp_r.last)
               report_mismatch($sformatf("last %b exp %b", rsp_tlast, exp_r.last));
         end
      end
      if (reset) rsp_tready <= 1'b0;
      else if (quiet) rsp_tready <= 1'b1;
      else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WatchLimit) begin
         $display("tb_topological_sort_engine: FAIL");
         $finish;
      end
   end

   // tvalid drops at the transfer edge; the next item follows at once or after a random gap
   task automatic send_item(input logic func, input logic [5:0] s, input logic [5:0] d);
      if (!quiet && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 18)) @(posedge clock);
      else @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, d, s, func};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      if (func == FuncAdd) load_edge(s, d);
      else sort_graph();
   endtask

   task automatic write_count(input logic [6:0] val);
      while (pending_order.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      vcount_reg = val;
   endtask

   // random DAG (edges low->high through a shuffled order) or noisy graph
   task automatic random_graph(input int n, input int edges, input bit acyclic);
      int perm [64];
      int a, b, t;
      for (int i = 0; i < 64; i++) perm[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         a = $urandom_range(0, i);
         t = perm[i]; perm[i] = perm[a]; perm[a] = t;
      end
      for (int i = 0; i < edges; i++) begin
         a = $urandom_range(0, n - 1);
         b = $urandom_range(0, n - 1);
         if (acyclic) begin
            if (a == b) continue;
            if (a > b) begin t = a; a = b; b = t; end
            send_item(FuncAdd, 6'(perm[a]), 6'(perm[b]));
         end else if ($urandom_range(0, 9) == 0)
            send_item(FuncAdd, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
         else send_item(FuncAdd, 6'(a), 6'(b));
      end
      send_item(FuncFinish, 6'($urandom), 6'($urandom));
   endtask

   stim_row_type directed [] = '{
      '{FuncFinish, 6'd63, 6'd63, 1'b0, StatusOrdered},  // empty graph, 64 vertices
      '{FuncAdd,    6'd0,  6'd63, 1'b0, StatusOrdered},
      '{FuncAdd,    6'd63, 6'd1,  1'b0, StatusOrdered},
      '{FuncAdd,    6'd0,  6'd1,  1'b0, StatusOrdered},
      '{FuncFinish, 6'd0,  6'd0,  1'b0, StatusOrdered},
      '{FuncAdd,    6'd5,  6'd5,  1'b0, StatusOrdered},  // self loop
      '{FuncFinish, 6'd0,  6'd0,  1'b1, StatusCycle},
      '{FuncAdd,    6'd2,  6'd3,  1'b0, StatusOrdered},
      '{FuncAdd,    6'd3,  6'd2,  1'b0, StatusOrdered},
      '{FuncFinish, 6'd0,  6'd0,  1'b1, StatusCycle},
      '{FuncAdd,    6'd1,  6'd2,  1'b0, StatusOrdered},
      '{FuncAdd,    6'd2,  6'd1,  1'b0, StatusOrdered},
      '{FuncFinish, 6'd0,  6'd0,  1'b1, StatusCycle}
   };

   initial begin
      int nv;
      order_item_type first_r;
      vcount_reg = 7'd64;
      clear_graph();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].typed) begin
            send_item(directed[i].func, directed[i].src, directed[i].dst);
            first_r = pending_order[0];
            if (first_r.status !== directed[i].status)
               report_mismatch($sformatf("row %0d predictor status", i));
         end else send_item(directed[i].func, directed[i].src, directed[i].dst);
      end

      // range errors at the smallest count, overflow beats cycle
      write_count(7'd1);
      send_item(FuncAdd, 6'd0, 6'd0);
      send_item(FuncAdd, 6'd0, 6'd1);
      send_item(FuncFinish, 6'd0, 6'd0);
      send_item(FuncFinish, 6'd0, 6'd0);
      write_count(7'd0);
      send_item(FuncAdd, 6'd63, 6'd0);
      send_item(FuncFinish, 6'd0, 6'd0);
      // count above the maximum saturates; edge store overflow
      write_count(7'd127);
      for (int i = 0; i < 257; i++) send_item(FuncAdd, 6'(i % 63), 6'd63);
      send_item(FuncFinish, 6'd0, 6'd0);
      // count lowered after loading
      write_count(7'd8);
      send_item(FuncAdd, 6'd0, 6'd7);
      send_item(FuncAdd, 6'd7, 6'd1);
      write_count(7'd4);
      send_item(FuncAdd, 6'd2, 6'd3);
      send_item(FuncFinish, 6'd0, 6'd0);

      for (int g = 0; g < 8; g++) begin
         if (g == 6) quiet = 1'b1;
         if (g % 4 == 0) begin
            nv = (g == 0) ? 64 : $urandom_range(1, 12);
            write_count(nv[6:0]);
         end
         random_graph(eff_count(), $urandom_range(0, 8), $urandom_range(0, 3) != 0);
      end

      while (pending_order.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("tb_topological_sort_engine: PASS");
      else $display("tb_topological_sort_engine: FAIL");
      $finish;
   end
endmodule
